// ----- rtl/core/gwvd_pkg.sv -----
// Shared types, register codes and fixed-point constants of the Gerstner wave core.
// No dependencies; every other file of the core imports this package.
`default_nettype none

package gwvd_pkg;

    localparam int FIELD_W = 16;
    localparam int REG_W = 48;
    localparam int NUM_REGS = 5;
    localparam int IDX_W = 3;

    localparam int DEF_NUM_WAVES = 3;
    localparam int DEF_CORDIC_STAGES = 14;
    localparam int ATAN_LEN = 20;

    localparam logic [IDX_W-1:0] REG_AMP     = 3'd0;
    localparam logic [IDX_W-1:0] REG_OMEGA   = 3'd1;
    localparam logic [IDX_W-1:0] REG_WAVENUM = 3'd2;
    localparam logic [IDX_W-1:0] REG_PHASE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_HORIZ   = 3'd4;

    localparam logic [REG_W-1:0] RST_AMP     = 48'd3298568438016;
    localparam logic [REG_W-1:0] RST_OMEGA   = 48'd5497625248512;
    localparam logic [REG_W-1:0] RST_WAVENUM = 48'd34540970343850;
    localparam logic [REG_W-1:0] RST_PHASE   = 48'd3517658759680;
    localparam logic [REG_W-1:0] RST_HORIZ   = 48'd420909481992;

    localparam int TWO_PI_Q20 = 6588397;
    localparam int PI_Q20 = 3294199;
    localparam int HALF_PI_Q20 = 1647099;
    localparam int CORDIC_X0 = 636751;
    localparam int FRAC = 20;

    localparam int THETA_W = 37;
    localparam int RED_STEPS = 13;
    localparam int ANG_W = 24;
    localparam int PROD_W = FIELD_W + 1 + ANG_W;
    localparam int SUM_W = PROD_W + 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef struct packed {
        logic signed [FIELD_W-1:0] rest_x;
        logic [FIELD_W-1:0]        time_now;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] displaced_x;
        logic signed [FIELD_W-1:0] surface_height;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_status;

    function automatic logic [FIELD_W-1:0] field_of(input logic [REG_W-1:0] r,
                                                    input logic [1:0] w);
        logic [63:0] e;
        e = {16'd0, r};
        return e[{w, 4'b0000} +: FIELD_W];
    endfunction

    function automatic logic signed [ANG_W-1:0] atan_q20(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0: v = 24'sd823550;
            1: v = 24'sd486170;
            2: v = 24'sd256878;
            3: v = 24'sd130394;
            4: v = 24'sd65451;
            5: v = 24'sd32757;
            6: v = 24'sd16383;
            7: v = 24'sd8192;
            8: v = 24'sd4096;
            9: v = 24'sd2048;
            10: v = 24'sd1024;
            11: v = 24'sd512;
            12: v = 24'sd256;
            13: v = 24'sd128;
            14: v = 24'sd64;
            15: v = 24'sd32;
            16: v = 24'sd16;
            17: v = 24'sd8;
            18: v = 24'sd4;
            19: v = 24'sd2;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gwvd_front.sv -----
// Front end: input register, per-wave phase products and the biased phase sum.
// Depends on gwvd_pkg.
`default_nettype none

module gwvd_front
    import gwvd_pkg::*;
#(
    parameter int NUM_WAVES = DEF_NUM_WAVES
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire t_in_item                             i_in_data,
    input  wire logic [NUM_WAVES-1:0][FIELD_W-1:0]    i_wavenum,
    input  wire logic [NUM_WAVES-1:0][FIELD_W-1:0]    i_omega,
    input  wire logic [NUM_WAVES-1:0][FIELD_W-1:0]    i_phase,
    input  wire t_q_status                            i_q_status,
    output logic                                      o_push,
    output logic signed [FIELD_W-1:0]                 o_push_x,
    output logic [NUM_WAVES-1:0][THETA_W-1:0]         o_push_theta
);

    localparam logic [THETA_W-1:0] BIAS = THETA_W'(TWO_PI_Q20) << (RED_STEPS - 1);

    logic                                  r_valid, n_valid;
    logic signed [FIELD_W-1:0]             r_x;
    logic signed [2*FIELD_W:0]             r_kx [NUM_WAVES];
    logic [2*FIELD_W-1:0]                  r_wt [NUM_WAVES];
    logic [FIELD_W-1:0]                    r_ph [NUM_WAVES];
    logic                                  accept;

    assign o_in_stall = r_valid & i_q_status.full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_valid & ~i_q_status.full;
    assign o_push_x   = r_x;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= i_in_data.rest_x;
            for (int w = 0; w < NUM_WAVES; w++) begin
                r_kx[w] <= $signed({1'b0, i_wavenum[w]}) * i_in_data.rest_x;
                r_wt[w] <= i_omega[w] * i_in_data.time_now;
                r_ph[w] <= i_phase[w];
            end
        end
    end

    always_comb begin
        for (int w = 0; w < NUM_WAVES; w++) begin
            o_push_theta[w] = THETA_W'(r_kx[w]) - THETA_W'({r_wt[w], 2'b00})
                            + THETA_W'({r_ph[w], 10'd0}) + BIAS;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/gwvd_queue.sv -----
// Short queue between the front end and the back end.
// Depends on gwvd_pkg.
`default_nettype none

module gwvd_queue
    import gwvd_pkg::*;
#(
    parameter int DATA_W = FIELD_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_push_data,
    input  wire logic              i_pop,
    output t_q_status              o_status,
    output logic [DATA_W-1:0]      o_pop_data
);

    logic [DATA_W-1:0]  r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [Q_PTR_W:0]   r_cnt, n_cnt;

    assign o_status.full     = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_status.nonempty = (r_cnt != '0);
    assign o_pop_data        = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/gwvd_back.sv -----
// Back end: modulo-2pi reduction, quadrant fold, CORDIC lanes, weighting, sum, saturation.
// Depends on gwvd_pkg.
`default_nettype none

module gwvd_back
    import gwvd_pkg::*;
#(
    parameter int NUM_WAVES = DEF_NUM_WAVES,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic signed [FIELD_W-1:0]         i_x,
    input  wire logic [NUM_WAVES-1:0][THETA_W-1:0] i_theta,
    input  wire logic [NUM_WAVES-1:0][FIELD_W-1:0] i_amp,
    input  wire logic [NUM_WAVES-1:0][FIELD_W-1:0] i_hor,
    output logic                                   o_pop,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output t_out_item                              o_out_data
);

    localparam int S = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int L = RED_STEPS + 1 + S + 2;

    localparam logic signed [ANG_W-1:0] A_TWO_PI  = ANG_W'(TWO_PI_Q20);
    localparam logic signed [ANG_W-1:0] A_PI      = ANG_W'(PI_Q20);
    localparam logic signed [ANG_W-1:0] A_HALF_PI = ANG_W'(HALF_PI_Q20);
    localparam logic signed [ANG_W-1:0] A_X0      = ANG_W'(CORDIC_X0);
    localparam logic signed [SUM_W-1:0] RND       = SUM_W'(1) << (FRAC - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI    = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO    = -SUM_W'(32768);

    function automatic logic signed [FIELD_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [FIELD_W-1:0] r;
        priority if (v > SAT_HI) begin
            r = 16'sh7fff;
        end else if (v < SAT_LO) begin
            r = 16'sh8000;
        end else begin
            r = v[FIELD_W-1:0];
        end
        return r;
    endfunction

    logic                          en;
    logic                          r_out_valid;
    t_out_item                     r_out;
    logic [L-1:0]                  r_vp;
    logic signed [FIELD_W-1:0]     r_xp [L];

    logic [THETA_W-1:0]            r_red [RED_STEPS][NUM_WAVES];
    logic signed [ANG_W-1:0]       r_cx [S+1][NUM_WAVES];
    logic signed [ANG_W-1:0]       r_cy [S+1][NUM_WAVES];
    logic signed [ANG_W-1:0]       r_cz [S+1][NUM_WAVES];
    logic [NUM_WAVES-1:0]          r_ng [S+1];
    logic signed [PROD_W-1:0]      r_px [NUM_WAVES];
    logic signed [PROD_W-1:0]      r_py [NUM_WAVES];
    logic signed [SUM_W-1:0]       r_sx, r_sy;

    assign en          = ~(r_out_valid & i_out_stall);
    assign o_pop       = i_valid & en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp        <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vp        <= {r_vp[L-2:0], i_valid};
            r_out_valid <= r_vp[L-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xp[0] <= i_x;
            for (int k = 1; k < L; k++) begin
                r_xp[k] <= r_xp[k-1];
            end
        end
    end

    for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
        localparam logic [THETA_W-1:0] SUBV = THETA_W'(TWO_PI_Q20) << (RED_STEPS - 1 - j);
        logic [THETA_W-1:0] src [NUM_WAVES];
        for (genvar w = 0; w < NUM_WAVES; w++) begin : g_src
            if (j == 0) begin : g_first
                assign src[w] = i_theta[w];
            end else begin : g_next
                assign src[w] = r_red[j-1][w];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int w = 0; w < NUM_WAVES; w++) begin
                    r_red[j][w] <= (src[w] >= SUBV) ? src[w] - SUBV : src[w];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [ANG_W-1:0] r0;
        logic signed [ANG_W-1:0] r1;
        if (en) begin
            for (int w = 0; w < NUM_WAVES; w++) begin
                r0 = $signed(r_red[RED_STEPS-1][w][ANG_W-1:0]);
                r1 = (r0 > A_PI) ? r0 - A_TWO_PI : r0;
                r_cx[0][w] <= A_X0;
                r_cy[0][w] <= '0;
                priority if (r1 > A_HALF_PI) begin
                    r_cz[0][w] <= r1 - A_PI;
                    r_ng[0][w] <= 1'b1;
                end else if (r1 < -A_HALF_PI) begin
                    r_cz[0][w] <= r1 + A_PI;
                    r_ng[0][w] <= 1'b1;
                end else begin
                    r_cz[0][w] <= r1;
                    r_ng[0][w] <= 1'b0;
                end
            end
        end
    end

    for (genvar i = 0; i < S; i++) begin : g_cordic
        localparam logic signed [ANG_W-1:0] AT = atan_q20(i);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ng[i+1] <= r_ng[i];
                for (int w = 0; w < NUM_WAVES; w++) begin
                    if (r_cz[i][w] >= 0) begin
                        r_cx[i+1][w] <= r_cx[i][w] - (r_cy[i][w] >>> i);
                        r_cy[i+1][w] <= r_cy[i][w] + (r_cx[i][w] >>> i);
                        r_cz[i+1][w] <= r_cz[i][w] - AT;
                    end else begin
                        r_cx[i+1][w] <= r_cx[i][w] + (r_cy[i][w] >>> i);
                        r_cy[i+1][w] <= r_cy[i][w] - (r_cx[i][w] >>> i);
                        r_cz[i+1][w] <= r_cz[i][w] + AT;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [ANG_W-1:0] sn;
        logic signed [ANG_W-1:0] cs;
        if (en) begin
            for (int w = 0; w < NUM_WAVES; w++) begin
                sn = r_ng[S][w] ? -r_cy[S][w] : r_cy[S][w];
                cs = r_ng[S][w] ? -r_cx[S][w] : r_cx[S][w];
                r_px[w] <= $signed({1'b0, i_hor[w]}) * sn;
                r_py[w] <= $signed({1'b0, i_amp[w]}) * cs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [SUM_W-1:0] ax;
        logic signed [SUM_W-1:0] ay;
        if (en) begin
            ax = '0;
            ay = '0;
            for (int w = 0; w < NUM_WAVES; w++) begin
                ax = ax + SUM_W'(r_px[w]);
                ay = ay + SUM_W'(r_py[w]);
            end
            r_sx <= ax;
            r_sy <= ay;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [SUM_W-1:0] qx;
        logic signed [SUM_W-1:0] qy;
        if (en) begin
            qx = (r_sx + RND) >>> FRAC;
            qy = (r_sy + RND) >>> FRAC;
            r_out.displaced_x    <= sat16(SUM_W'(r_xp[L-1]) - qx);
            r_out.surface_height <= sat16(qy);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/gerstner_wave_vertex_displacement_core.sv -----
// Gerstner wave vertex displacement core: configuration registers, front end, queue, back end.
// Throughput: one beat per cycle; the back end pipeline advances whenever its output
// register is empty or taken, and the four-entry queue absorbs the front end meanwhile.
// Reset: synchronous active-low; clears valids and pointers, loads register defaults.
// Depends on gwvd_pkg, gwvd_front, gwvd_queue, gwvd_back.
`default_nettype none

module gerstner_wave_vertex_displacement_core
    import gwvd_pkg::*;
#(
    parameter int NUM_WAVES = DEF_NUM_WAVES,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [REG_W-1:0] i_cfg_data
);

    localparam int Q_W = FIELD_W + NUM_WAVES * THETA_W;

    logic [REG_W-1:0] r_amp, r_omega, r_wavenum, r_phase, r_horiz;

    logic [NUM_WAVES-1:0][FIELD_W-1:0] amp, omega, wavenum, phase, horiz;

    t_q_status                         q_status;
    logic                              push, pop;
    logic signed [FIELD_W-1:0]         push_x, pop_x;
    logic [NUM_WAVES-1:0][THETA_W-1:0] push_theta, pop_theta;
    logic [Q_W-1:0]                    pop_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp     <= RST_AMP;
            r_omega   <= RST_OMEGA;
            r_wavenum <= RST_WAVENUM;
            r_phase   <= RST_PHASE;
            r_horiz   <= RST_HORIZ;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_AMP:     r_amp     <= i_cfg_data;
                REG_OMEGA:   r_omega   <= i_cfg_data;
                REG_WAVENUM: r_wavenum <= i_cfg_data;
                REG_PHASE:   r_phase   <= i_cfg_data;
                REG_HORIZ:   r_horiz   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int w = 0; w < NUM_WAVES; w++) begin
            amp[w]     = field_of(r_amp, 2'(w));
            omega[w]   = field_of(r_omega, 2'(w));
            wavenum[w] = field_of(r_wavenum, 2'(w));
            phase[w]   = field_of(r_phase, 2'(w));
            horiz[w]   = field_of(r_horiz, 2'(w));
        end
    end

    gwvd_front #(
        .NUM_WAVES (NUM_WAVES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_wavenum    (wavenum),
        .i_omega      (omega),
        .i_phase      (phase),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_push_x     (push_x),
        .o_push_theta (push_theta)
    );

    gwvd_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({push_x, push_theta}),
        .i_pop       (pop),
        .o_status    (q_status),
        .o_pop_data  (pop_data)
    );

    assign pop_x     = pop_data[Q_W-1 -: FIELD_W];
    assign pop_theta = pop_data[NUM_WAVES*THETA_W-1:0];

    gwvd_back #(
        .NUM_WAVES     (NUM_WAVES),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_status.nonempty),
        .i_x         (pop_x),
        .i_theta     (pop_theta),
        .i_amp       (amp),
        .i_hor       (horiz),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_status.full))
        else $error("queue written while full");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_status.nonempty)
        else $error("queue read while empty");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_status.full)
        else $error("input stalled with room in queue");

    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
